@@ sv/btff_pkg.sv @@
// btff_pkg: types and constants shared by the boundary tag first-fit allocator
// depends on nothing
package btff_pkg;
   localparam int unsigned TAG_W  = 13;
   localparam int unsigned SIZE_W = 12;
   localparam int unsigned CFG_W  = 13;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_NOFIT = 2'd1;
   localparam logic [1:0] STATUS_NULL  = 2'd2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LAYOUT,
      ST_DISPATCH,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_FREE_RD,
      ST_FREE_CHK,
      ST_LEFT_CHK,
      ST_RIGHT_CHK,
      ST_WR_A,
      ST_WR_B,
      ST_WR_C,
      ST_WR_D,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [11:0] payload_address;
      logic [1:0]  status;
   } rsp_word_type;
endpackage

@@ sv/btff_if.sv @@
// btff_req_if / btff_rsp_if: valid/ready channels of the allocator
// depends on nothing
interface btff_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [11:0] request_words;
   logic [11:0] block_address;
   modport source (output valid, func, request_words, block_address, input ready);
   modport sink (input valid, func, request_words, block_address, output ready);
endinterface

interface btff_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] payload_address;
   logic [1:0]  status;
   modport source (output valid, payload_address, status, input ready);
   modport sink (input valid, payload_address, status, output ready);
endinterface

@@ sv/btff_ram.sv @@
// btff_ram: generic single port ram with registered read
// depends on nothing
module btff_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

@@ sv/boundary_tag_first_fit_allocator_unit.sv @@
// boundary_tag_first_fit_allocator_unit: top level, sequencer around the tag ram
// depends on btff_pkg, btff_if, btff_ram
// allocate walks the blocks first fit, then writes the used tags, and the free tags on a split; free merges neighbours
// first request after reset or a csr write first lays out the arena
// throughput: one word at a time; a result word waits in the output register until taken
// reset: synchronous active high; arena marked not laid out, arena_words 4096
// no clearing pass: first request lays out one free block (two tag writes)
module boundary_tag_first_fit_allocator_unit #(
   parameter int ARENA_WORDS = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   btff_req_if.sink                  req,
   btff_rsp_if.source                rsp,
   input  logic                      csr_write_enable,
   input  logic [btff_pkg::CFG_W-1:0] csr_write_data
);
   import btff_pkg::*;

   localparam int AW = $clog2(ARENA_WORDS);
   localparam int TOP = (ARENA_WORDS < 4096) ? ARENA_WORDS : 4096;
   // address arithmetic width, 15 bits, three over the 12-bit sizes, so sums never wrap
   localparam int XW = 15;

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   cfg_ff;
   logic               ready_ff, ready_in;
   logic               func_ff, func_in;
   logic [11:0]        rq_ff, rq_in;
   logic [XW-1:0]      h_ff, h_in;        // block header index
   logic [11:0]        s_ff, s_in;        // size of current block
   logic [XW-1:0]      start_ff, start_in;
   logic [XW-1:0]      total_ff, total_in;
   logic               rok_ff, rok_in;    // right neighbour may be read
   rsp_word_type       out_ff, out_in;
   logic               ov_ff, ov_in;
   // marks that the current tag writes are the arena layout
   logic               lay_ff;

   logic               wen;
   logic [XW-1:0]      waddr;
   logic [XW-1:0]      raddr;
   logic [TAG_W-1:0]   wdata;
   logic [TAG_W-1:0]   rdata;
   logic [AW-1:0]      ram_addr;

   // clamped arena length
   logic [XW-1:0] alen;
   always_comb begin
      alen = XW'(cfg_ff);
      if (alen < XW'(3)) alen = XW'(3);
      if (alen > XW'(TOP)) alen = XW'(TOP);
   end

   logic [11:0]   rs;
   logic          ru;
   logic [11:0]   req1;
   logic [XW-1:0] left_w;
   assign rs   = rdata[SIZE_W-1:0];
   assign ru   = rdata[TAG_W-1];
   assign req1 = (rq_ff == 12'd0) ? 12'd1 : rq_ff;
   assign left_w = XW'(s_ff) - XW'(req1);

   btff_ram #(.WIDTH(TAG_W), .DEPTH(ARENA_WORDS)) u_tags (
      .clock   (clock),
      .wr_en   (wen),
      .addr    (ram_addr),
      .wr_data (wdata),
      .rd_data (rdata)
   );
   assign ram_addr = AW'(wen ? waddr : raddr);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cfg_ff   <= CFG_W'(4096);
         ready_ff <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cfg_ff   <= csr_write_enable ? csr_write_data : cfg_ff;
         ready_ff <= csr_write_enable ? 1'b0 : ready_in;
         ov_ff    <= ov_in;
      end
      func_ff  <= func_in;
      rq_ff    <= rq_in;
      h_ff     <= h_in;
      s_ff     <= s_in;
      start_ff <= start_in;
      total_ff <= total_in;
      rok_ff   <= rok_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) lay_ff <= 1'b0;
      else if (state_ff == ST_LAYOUT) lay_ff <= 1'b1;
      else if (state_ff == ST_WR_D) lay_ff <= 1'b0;
   end

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      func_in  = func_ff;
      rq_in    = rq_ff;
      h_in     = h_ff;
      s_in     = s_ff;
      start_in = start_ff;
      total_in = total_ff;
      rok_in   = rok_ff;
      out_in   = out_ff;
      ov_in    = ov_ff && !rsp.ready;
      wen      = 1'b0;
      waddr    = '0;
      wdata    = '0;
      raddr    = h_ff;
      req.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = !ov_ff || rsp.ready;
            if (req.valid && req.ready) begin
               func_in = req.func;
               rq_in   = req.request_words;
               h_in    = XW'(req.block_address) - XW'(1);
               state_in = ready_ff ? ST_DISPATCH : ST_LAYOUT;
            end
         end
         ST_LAYOUT: begin
            // header then footer of the single free block
            s_in     = 12'(alen - XW'(2));
            start_in = '0;
            total_in = alen - XW'(2);
            ready_in = 1'b1;
            state_in = ST_WR_C;
            rok_in   = 1'b1;
         end
         ST_DISPATCH: begin
            out_in.payload_address = '0;
            out_in.status = STATUS_DONE;
            if (func_ff == FUNC_ALLOC) begin
               h_in = '0;
               state_in = ST_WALK_RD;
            end else if (h_ff == {XW{1'b1}}) begin
               out_in.status = STATUS_NULL;
               state_in = ST_RESP;
            end else if (h_ff + XW'(1) >= alen) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_FREE_RD;
            end
         end
         ST_WALK_RD: begin
            raddr = h_ff;
            if (h_ff + XW'(1) < alen) state_in = ST_WALK_CHK;
            else begin
               out_in.status = STATUS_NOFIT;
               state_in = ST_RESP;
            end
         end
         ST_WALK_CHK: begin
            s_in = rs;
            if (h_ff + XW'(rs) + XW'(1) >= alen) begin
               out_in.status = STATUS_NOFIT;
               state_in = ST_RESP;
            end else if (!ru && rs >= req1) begin
               out_in.payload_address = 12'(h_ff + XW'(1));
               state_in = ST_WR_A;
            end else begin
               h_in = h_ff + XW'(rs) + XW'(2);
               raddr = h_in;
               state_in = ST_WALK_RD;
            end
         end
         ST_WR_A: begin
            // used header; size is req or whole block
            wen   = 1'b1;
            waddr = h_ff;
            wdata = {1'b1, (left_w >= XW'(3)) ? req1 : s_ff};
            state_in = ST_WR_B;
         end
         ST_WR_B: begin
            wen   = 1'b1;
            waddr = h_ff + XW'((left_w >= XW'(3)) ? req1 : s_ff) + XW'(1);
            wdata = {1'b1, (left_w >= XW'(3)) ? req1 : s_ff};
            start_in = h_ff + XW'(req1) + XW'(2);
            total_in = left_w - XW'(2);
            state_in = (left_w >= XW'(3)) ? ST_WR_C : ST_RESP;
         end
         ST_FREE_RD: begin
            raddr = h_ff;
            state_in = ST_FREE_CHK;
         end
         ST_FREE_CHK: begin
            s_in     = rs;
            start_in = h_ff;
            total_in = XW'(rs);
            rok_in   = h_ff + XW'(rs) + XW'(2) < alen;
            if (h_ff + XW'(rs) + XW'(1) >= alen) state_in = ST_RESP;
            else if (h_ff >= XW'(1)) begin
               raddr = h_ff - XW'(1);
               state_in = ST_LEFT_CHK;
            end else begin
               raddr = h_ff + XW'(rs) + XW'(2);
               state_in = rok_in ? ST_RIGHT_CHK : ST_WR_C;
            end
         end
         ST_LEFT_CHK: begin
            if (!ru && h_ff >= XW'(rs) + XW'(2)) begin
               start_in = h_ff - XW'(rs) - XW'(2);
               total_in = total_ff + XW'(rs) + XW'(2);
            end
            raddr = h_ff + XW'(s_ff) + XW'(2);
            state_in = rok_ff ? ST_RIGHT_CHK : ST_WR_C;
         end
         ST_RIGHT_CHK: begin
            if (!ru && h_ff + XW'(s_ff) + XW'(2) + XW'(rs) + XW'(1) < alen)
               total_in = total_ff + XW'(rs) + XW'(2);
            state_in = ST_WR_C;
         end
         ST_WR_C: begin
            // free block header
            wen   = 1'b1;
            waddr = start_ff;
            wdata = {1'b0, total_ff[11:0]};
            state_in = ST_WR_D;
         end
         ST_WR_D: begin
            // free block footer; after the layout go on to dispatch
            wen   = 1'b1;
            waddr = start_ff + total_ff + XW'(1);
            wdata = {1'b0, total_ff[11:0]};
            state_in = lay_ff ? ST_DISPATCH : ST_RESP;
         end
         ST_RESP: begin
            ov_in    = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp.valid           = ov_ff;
   assign rsp.payload_address = out_ff.payload_address;
   assign rsp.status          = out_ff.status;

   a_held: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !rsp.ready |=> ov_ff && $stable(out_ff))
      else $error("result word changed while stalled");
   a_one: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req.ready)
      else $error("input taken while busy");
   a_free_addr: assert property (@(posedge clock) disable iff (reset)
      ov_ff && out_ff.status != STATUS_DONE |-> out_ff.payload_address == 12'd0)
      else $error("address on failed request");
endmodule
